/* rtl/core/mbe_pkg.sv */
`default_nettype none

package mbe_pkg;

  // Image geometry and fixed-point format.
  localparam int unsigned IMAGE_WIDTH   = 1024;
  localparam int unsigned IMAGE_HEIGHT  = 1024;
  localparam int unsigned FRACTION_BITS = 28;

  // Field widths.
  localparam int unsigned COORD_W    = 10;
  localparam int unsigned ITER_W     = 12;
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned ZOOM_W     = 31;
  localparam int unsigned LIMIT_W    = 31;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned PROD_W     = 2 * WORD_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic signed [PROD_W-1:0] WIDE_MAX = PROD_W'(WORD_MAX);
  localparam logic signed [PROD_W-1:0] WIDE_MIN = PROD_W'(WORD_MIN);
  localparam logic signed [PROD_W-1:0] FIX_TWO  = PROD_W'(2) << FRACTION_BITS;

  // Shared divider geometry: radix 16, four quotient bits per cycle.
  localparam int unsigned DIV_RADIX_BITS = 4;
  localparam int unsigned MAP_NUM_W      = COORD_W + 2 + FRACTION_BITS;
  localparam int unsigned RAMP_NUM_W     = COLOR_W + ITER_W;
  localparam int unsigned DIV_RAW_W      = (MAP_NUM_W > RAMP_NUM_W) ? MAP_NUM_W : RAMP_NUM_W;
  localparam int unsigned DIV_CYCLES     = (DIV_RAW_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
  localparam int unsigned DIV_NUM_W      = DIV_CYCLES * DIV_RADIX_BITS;
  localparam int unsigned DIV_CNT_W      = $clog2(DIV_CYCLES + 1);
  localparam int unsigned DEN_IMG_W      =
      ($clog2(IMAGE_WIDTH + 1) > $clog2(IMAGE_HEIGHT + 1)) ?
      $clog2(IMAGE_WIDTH + 1) : $clog2(IMAGE_HEIGHT + 1);
  localparam int unsigned DIV_DEN_W      = (DEN_IMG_W > ITER_W) ? DEN_IMG_W : ITER_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZOOM      = 3'd0,
    REG_OFF_REAL  = 3'd1,
    REG_OFF_IMAG  = 3'd2,
    REG_MAX_ITER  = 3'd3,
    REG_ESC_LIMIT = 3'd4,
    REG_RAMP_LOW  = 3'd5,
    REG_RAMP_HIGH = 3'd6,
    REG_INSIDE    = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic        [ZOOM_W-1:0]  zoom_factor;
    logic signed [WORD_W-1:0]  offset_real;
    logic signed [WORD_W-1:0]  offset_imag;
    logic        [ITER_W-1:0]  max_iterations;
    logic        [LIMIT_W-1:0] escape_limit;
    logic        [COLOR_W-1:0] ramp_low_color;
    logic        [COLOR_W-1:0] ramp_high_color;
    logic        [COLOR_W-1:0] inside_color;
  } cfg_t;

  typedef enum logic [1:0] {
    DIV_COL,
    DIV_ROW,
    DIV_RAMP
  } div_sel_e;

  typedef enum logic [1:0] {
    MUL_MAP,
    MUL_ITER,
    MUL_RAMP
  } mul_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COL_START,
    ST_COL_WAIT,
    ST_ROW_START,
    ST_ROW_WAIT,
    ST_MAP_MUL,
    ST_MAP_ADD,
    ST_ITER_MUL,
    ST_ITER_STEP,
    ST_RAMP_MUL,
    ST_RAMP_START,
    ST_RAMP_WAIT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic     load_in;
    logic     div_start;
    div_sel_e div_sel;
    logic     take_ux;
    logic     take_uy;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     map_en;
    logic     iter_en;
    logic     esc_en;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic escape;
    logic at_limit;
  } dp_sts_t;

endpackage

`default_nettype wire

/* rtl/core/mbe_in_if.sv */
`default_nettype none

interface mbe_in_if;
  logic                       valid;
  logic                       ready;
  logic [mbe_pkg::COORD_W-1:0] pixel_col;
  logic [mbe_pkg::COORD_W-1:0] pixel_row;

  modport source (output valid, output pixel_col, output pixel_row, input ready);
  modport sink   (input valid, input pixel_col, input pixel_row, output ready);
endinterface

`default_nettype wire

/* rtl/core/mbe_out_if.sv */
`default_nettype none

interface mbe_out_if;
  logic                        valid;
  logic                        ready;
  logic [mbe_pkg::COORD_W-1:0] out_col;
  logic [mbe_pkg::COORD_W-1:0] out_row;
  logic [mbe_pkg::COLOR_W-1:0] pixel_color;
  logic                        escaped;
  logic [mbe_pkg::ITER_W-1:0]  iteration_count;

  modport source (
    output valid, output out_col, output out_row, output pixel_color,
    output escaped, output iteration_count, input ready
  );
  modport sink (
    input valid, input out_col, input out_row, input pixel_color,
    input escaped, input iteration_count, output ready
  );
endinterface

`default_nettype wire

/* rtl/core/mbe_div.sv */
`default_nettype none

// Unsigned restoring divider, several quotient bits per cycle.
module mbe_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [mbe_pkg::DIV_NUM_W-1:0] num_i,
  input  wire logic [mbe_pkg::DIV_DEN_W-1:0] den_i,
  output logic                               busy_o,
  output logic      [mbe_pkg::DIV_NUM_W-1:0] quo_o,
  output logic      [mbe_pkg::DIV_DEN_W-1:0] rem_o
);

  logic                            busy_q, busy_d;
  logic [mbe_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [mbe_pkg::DIV_NUM_W-1:0]   num_q, num_step;
  logic [mbe_pkg::DIV_DEN_W-1:0]   rem_q, rem_step;
  logic [mbe_pkg::DIV_DEN_W-1:0]   den_q;
  logic [mbe_pkg::DIV_DEN_W:0]     trial;

  // The dividend register shifts left; quotient bits enter at the bottom.
  always_comb begin
    rem_step = rem_q;
    num_step = num_q;
    trial    = '0;
    for (int k = 0; k < mbe_pkg::DIV_RADIX_BITS; k++) begin
      trial    = {rem_step, num_step[mbe_pkg::DIV_NUM_W-1]};
      num_step = num_step << 1;
      if (trial >= {1'b0, den_q}) begin
        rem_step    = mbe_pkg::DIV_DEN_W'(trial - {1'b0, den_q});
        num_step[0] = 1'b1;
      end else begin
        rem_step = trial[mbe_pkg::DIV_DEN_W-1:0];
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = mbe_pkg::DIV_CNT_W'(mbe_pkg::DIV_CYCLES);
    end else if (busy_q) begin
      cnt_d = cnt_q - mbe_pkg::DIV_CNT_W'(1);
      if (cnt_q == mbe_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      num_q <= num_step;
      rem_q <= rem_step;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = num_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

/* rtl/core/mbe_dp.sv */
`default_nettype none

module mbe_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire mbe_pkg::cfg_t               cfg_i,
  input  wire mbe_pkg::dp_cmd_t            cmd_i,
  output mbe_pkg::dp_sts_t                 sts_o,
  input  wire logic [mbe_pkg::COORD_W-1:0] in_col_i,
  input  wire logic [mbe_pkg::COORD_W-1:0] in_row_i,
  output logic      [mbe_pkg::COORD_W-1:0] out_col_o,
  output logic      [mbe_pkg::COORD_W-1:0] out_row_o,
  output logic      [mbe_pkg::COLOR_W-1:0] pixel_color_o,
  output logic                             escaped_o,
  output logic      [mbe_pkg::ITER_W-1:0]  iteration_count_o
);

  function automatic logic signed [mbe_pkg::WORD_W-1:0] sat_word(
    input logic signed [mbe_pkg::PROD_W-1:0] v
  );
    if (v > mbe_pkg::WIDE_MAX) begin
      return mbe_pkg::WORD_MAX;
    end else if (v < mbe_pkg::WIDE_MIN) begin
      return mbe_pkg::WORD_MIN;
    end
    return signed'(v[mbe_pkg::WORD_W-1:0]);
  endfunction

  logic        [mbe_pkg::COORD_W-1:0]  col_q, row_q;
  logic signed [mbe_pkg::WORD_W-1:0]   ux_q, uy_q, cr_q, ci_q, zr_q, zi_q;
  logic signed [mbe_pkg::PROD_W-1:0]   p0_q, p1_q, p2_q;
  logic        [mbe_pkg::ITER_W-1:0]   cnt_q, idx_q;
  logic                                esc_q;

  logic        [mbe_pkg::DIV_NUM_W-1:0] div_num, div_quo;
  logic        [mbe_pkg::DIV_DEN_W-1:0] div_den, div_rem;
  logic                                 div_busy;

  logic signed [mbe_pkg::PROD_W-1:0]   quo_wide;
  logic signed [mbe_pkg::WORD_W-1:0]   zoom_s;
  logic signed [mbe_pkg::WORD_W-1:0]   a0, b0, a1, b1, a2, b2;
  logic        [mbe_pkg::PROD_W-1:0]   mag, lim_wide;
  logic signed [mbe_pkg::PROD_W-1:0]   sq_diff;
  logic signed [mbe_pkg::WORD_W-1:0]   nr, ni, cr_new, ci_new;
  logic                                ramp_up;
  logic        [mbe_pkg::COLOR_W-1:0]  ramp_diff, quo_c, ramp_color;

  // Operand selection for the shared divider.
  always_comb begin
    unique case (cmd_i.div_sel)
      mbe_pkg::DIV_COL: begin
        div_num = mbe_pkg::DIV_NUM_W'(col_q) << (mbe_pkg::FRACTION_BITS + 2);
        div_den = mbe_pkg::DIV_DEN_W'(mbe_pkg::IMAGE_WIDTH);
      end
      mbe_pkg::DIV_ROW: begin
        div_num = mbe_pkg::DIV_NUM_W'(row_q) << (mbe_pkg::FRACTION_BITS + 2);
        div_den = mbe_pkg::DIV_DEN_W'(mbe_pkg::IMAGE_HEIGHT);
      end
      mbe_pkg::DIV_RAMP: begin
        div_num = mbe_pkg::DIV_NUM_W'(p2_q[mbe_pkg::RAMP_NUM_W-1:0]);
        div_den = mbe_pkg::DIV_DEN_W'(cfg_i.max_iterations);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  mbe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  assign quo_wide = signed'(mbe_pkg::PROD_W'(div_quo));
  assign zoom_s   = signed'({1'b0, cfg_i.zoom_factor});

  // Ramp span and direction.
  assign ramp_up   = cfg_i.ramp_high_color >= cfg_i.ramp_low_color;
  assign ramp_diff = ramp_up ? cfg_i.ramp_high_color - cfg_i.ramp_low_color
                             : cfg_i.ramp_low_color - cfg_i.ramp_high_color;

  // Multiplier operands.
  always_comb begin
    a0 = zr_q;
    b0 = zr_q;
    a1 = zi_q;
    b1 = zi_q;
    a2 = zr_q;
    b2 = zi_q;
    unique case (cmd_i.mul_sel)
      mbe_pkg::MUL_MAP: begin
        a0 = ux_q;
        b0 = zoom_s;
        a1 = uy_q;
        b1 = zoom_s;
      end
      mbe_pkg::MUL_ITER: begin
      end
      mbe_pkg::MUL_RAMP: begin
        a2 = signed'(mbe_pkg::WORD_W'(ramp_diff));
        b2 = signed'(mbe_pkg::WORD_W'(idx_q));
      end
      default: begin
      end
    endcase
  end

  // Iteration step from the registered products of the current z.
  assign mag      = $unsigned(p0_q) + $unsigned(p1_q);
  assign lim_wide = mbe_pkg::PROD_W'(cfg_i.escape_limit) << mbe_pkg::FRACTION_BITS;
  assign sq_diff  = p0_q - p1_q;
  assign nr = sat_word((sq_diff >>> mbe_pkg::FRACTION_BITS) + mbe_pkg::PROD_W'(cr_q));
  assign ni = sat_word((p2_q >>> (mbe_pkg::FRACTION_BITS - 1)) + mbe_pkg::PROD_W'(ci_q));

  assign cr_new = sat_word(mbe_pkg::PROD_W'(sat_word(p0_q >>> mbe_pkg::FRACTION_BITS))
                           + mbe_pkg::PROD_W'(cfg_i.offset_real));
  assign ci_new = sat_word(mbe_pkg::PROD_W'(sat_word(p1_q >>> mbe_pkg::FRACTION_BITS))
                           + mbe_pkg::PROD_W'(cfg_i.offset_imag));

  // A falling ramp rounds the step up so that the color is rounded down.
  assign quo_c      = div_quo[mbe_pkg::COLOR_W-1:0];
  assign ramp_color = ramp_up ? cfg_i.ramp_low_color + quo_c
                              : cfg_i.ramp_low_color
                                - (quo_c + mbe_pkg::COLOR_W'(|div_rem));

  assign sts_o.div_busy = div_busy;
  assign sts_o.escape   = mag > lim_wide;
  assign sts_o.at_limit = cnt_q == cfg_i.max_iterations;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      col_q <= in_col_i;
      row_q <= in_row_i;
    end
    if (cmd_i.take_ux) begin
      ux_q <= sat_word(quo_wide - mbe_pkg::FIX_TWO);
    end
    if (cmd_i.take_uy) begin
      uy_q <= sat_word(mbe_pkg::FIX_TWO - quo_wide);
    end
    if (cmd_i.mul_en) begin
      p0_q <= mbe_pkg::PROD_W'(a0) * mbe_pkg::PROD_W'(b0);
      p1_q <= mbe_pkg::PROD_W'(a1) * mbe_pkg::PROD_W'(b1);
      p2_q <= mbe_pkg::PROD_W'(a2) * mbe_pkg::PROD_W'(b2);
    end
    if (cmd_i.map_en) begin
      cr_q  <= cr_new;
      ci_q  <= ci_new;
      zr_q  <= '0;
      zi_q  <= '0;
      cnt_q <= '0;
      esc_q <= 1'b0;
    end else if (cmd_i.iter_en) begin
      zr_q  <= nr;
      zi_q  <= ni;
      cnt_q <= cnt_q + mbe_pkg::ITER_W'(1);
    end else if (cmd_i.esc_en) begin
      esc_q <= 1'b1;
      idx_q <= cnt_q - mbe_pkg::ITER_W'(1);
    end
    if (cmd_i.out_load) begin
      out_col_o         <= col_q;
      out_row_o         <= row_q;
      escaped_o         <= esc_q;
      iteration_count_o <= esc_q ? idx_q : cnt_q;
      pixel_color_o     <= esc_q ? ramp_color : cfg_i.inside_color;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mbe_ctrl.sv */
`default_nettype none

module mbe_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  output mbe_pkg::dp_cmd_t      cmd_o,
  input  wire mbe_pkg::dp_sts_t sts_i
);

  mbe_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mbe_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.div_sel = mbe_pkg::DIV_COL;
    cmd_o.mul_sel = mbe_pkg::MUL_ITER;

    unique case (state_q)
      mbe_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = mbe_pkg::ST_COL_START;
        end
      end
      mbe_pkg::ST_COL_START: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = mbe_pkg::DIV_COL;
        state_d         = mbe_pkg::ST_COL_WAIT;
      end
      mbe_pkg::ST_COL_WAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.take_ux = 1'b1;
          state_d       = mbe_pkg::ST_ROW_START;
        end
      end
      mbe_pkg::ST_ROW_START: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = mbe_pkg::DIV_ROW;
        state_d         = mbe_pkg::ST_ROW_WAIT;
      end
      mbe_pkg::ST_ROW_WAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.take_uy = 1'b1;
          state_d       = mbe_pkg::ST_MAP_MUL;
        end
      end
      mbe_pkg::ST_MAP_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = mbe_pkg::MUL_MAP;
        state_d       = mbe_pkg::ST_MAP_ADD;
      end
      mbe_pkg::ST_MAP_ADD: begin
        cmd_o.map_en = 1'b1;
        state_d      = mbe_pkg::ST_ITER_MUL;
      end
      mbe_pkg::ST_ITER_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = mbe_pkg::MUL_ITER;
        state_d       = mbe_pkg::ST_ITER_STEP;
      end
      mbe_pkg::ST_ITER_STEP: begin
        // The escape test on the latest z wins over the iteration limit.
        priority if (sts_i.escape) begin
          cmd_o.esc_en = 1'b1;
          state_d      = mbe_pkg::ST_RAMP_MUL;
        end else if (sts_i.at_limit) begin
          state_d = mbe_pkg::ST_FINISH;
        end else begin
          cmd_o.iter_en = 1'b1;
          state_d       = mbe_pkg::ST_ITER_MUL;
        end
      end
      mbe_pkg::ST_RAMP_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = mbe_pkg::MUL_RAMP;
        state_d       = mbe_pkg::ST_RAMP_START;
      end
      mbe_pkg::ST_RAMP_START: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = mbe_pkg::DIV_RAMP;
        state_d         = mbe_pkg::ST_RAMP_WAIT;
      end
      mbe_pkg::ST_RAMP_WAIT: begin
        if (!sts_i.div_busy) begin
          state_d = mbe_pkg::ST_FINISH;
        end
      end
      mbe_pkg::ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = mbe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mbe_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* rtl/core/mandelbrot_escape_time_pixel_unit.sv */
`default_nettype none

// Channel   Direction  Word contents
// -------   ---------  ------------------------------------------------------------
// pix_i     in         pixel_col, pixel_row
// res_o     out        out_col, out_row, pixel_color, escaped, iteration_count
// cfg_*     in         write enable, register index, write data (no handshake)
//
// One pixel is worked on at a time. A word's run time grows with the number of iterations
// run (the escape index plus one, or max_iterations); a point that escapes also runs the
// color ramp. Each pass of the complex square-add loop multiplies, then updates and tests
// for escape; the shared radix-16 divider serves the column, row and ramp divisions.
// The finished result sits in an output register, so a new pixel is taken while the last
// result waits; a stalled result only holds the block once the next one is done.
// Reset is asynchronous; it resets the control state and loads the configuration defaults.

module mandelbrot_escape_time_pixel_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  mbe_in_if.sink                              pix_i,
  mbe_out_if.source                           res_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [mbe_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  mbe_pkg::cfg_t    cfg_q;
  mbe_pkg::dp_cmd_t cmd;
  mbe_pkg::dp_sts_t sts;

  // Configuration registers. Writes must arrive only while the block is idle; unchecked.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zoom_factor     <= mbe_pkg::ZOOM_W'(32'h1000_0000);
      cfg_q.offset_real     <= '0;
      cfg_q.offset_imag     <= '0;
      cfg_q.max_iterations  <= mbe_pkg::ITER_W'(42);
      cfg_q.escape_limit    <= mbe_pkg::LIMIT_W'(32'h4000_0000);
      cfg_q.ramp_low_color  <= '0;
      cfg_q.ramp_high_color <= mbe_pkg::COLOR_W'(24'hFF_FFFF);
      cfg_q.inside_color    <= mbe_pkg::COLOR_W'(24'hFF_6347);
    end else if (cfg_we_i) begin
      unique case (mbe_pkg::cfg_reg_e'(cfg_idx_i))
        mbe_pkg::REG_ZOOM:      cfg_q.zoom_factor     <= cfg_data_i[mbe_pkg::ZOOM_W-1:0];
        mbe_pkg::REG_OFF_REAL:  cfg_q.offset_real     <= signed'(cfg_data_i);
        mbe_pkg::REG_OFF_IMAG:  cfg_q.offset_imag     <= signed'(cfg_data_i);
        mbe_pkg::REG_MAX_ITER:  cfg_q.max_iterations  <= cfg_data_i[mbe_pkg::ITER_W-1:0];
        mbe_pkg::REG_ESC_LIMIT: cfg_q.escape_limit    <= cfg_data_i[mbe_pkg::LIMIT_W-1:0];
        mbe_pkg::REG_RAMP_LOW:  cfg_q.ramp_low_color  <= cfg_data_i[mbe_pkg::COLOR_W-1:0];
        mbe_pkg::REG_RAMP_HIGH: cfg_q.ramp_high_color <= cfg_data_i[mbe_pkg::COLOR_W-1:0];
        mbe_pkg::REG_INSIDE:    cfg_q.inside_color    <= cfg_data_i[mbe_pkg::COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The controller sequences mapping, iteration and the ramp; the datapath holds the
  // arithmetic, the shared divider and the output word register.
  mbe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  mbe_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .in_col_i          (pix_i.pixel_col),
    .in_row_i          (pix_i.pixel_row),
    .out_col_o         (res_o.out_col),
    .out_row_o         (res_o.out_row),
    .pixel_color_o     (res_o.pixel_color),
    .escaped_o         (res_o.escaped),
    .iteration_count_o (res_o.iteration_count)
  );

endmodule

`default_nettype wire

/* verif/mandelbrot_escape_time_pixel_unit_test.sv */
`timescale 1ns / 100ps

// Self-checking bench for the escape-time pixel unit.
//
// A driver process feeds pixel words from a job queue onto the input channel. Every word
// it hands over is run through a fixed-point model of the escape-time loop, and the
// predicted result word goes into a queue of pending pixels. A monitor process takes
// result words off the output channel and compares each field with the oldest pending
// pixel. The settings registers are only rewritten once every pending pixel has come
// back, so the model's copy of the settings always matches what the unit works with.
//
// Both channels idle in short random bursts, except in the last two random phases. One
// phase holds the output back for a long time, so the result register and the pixel in
// flight fill up and the input channel stalls while the driver keeps offering words.

module mandelbrot_escape_time_pixel_unit_test;
  import mbe_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int LONG_HOLD     = 600;
  localparam int SETTLE_CYCLES = 200;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_PIXELS  = 133;
  localparam int PRINT_CAP     = 100;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } pixel_job_t;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [COLOR_W-1:0] color;
    logic               escaped;
    logic [ITER_W-1:0]  iterations;
  } pixel_result_t;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = REG_ZOOM;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  mbe_in_if  pix_if ();
  mbe_out_if res_if ();

  mandelbrot_escape_time_pixel_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // The bench's own copy of the settings registers.
  cfg_t          settings;
  pixel_job_t    pixel_jobs_q[$];
  pixel_result_t pending_pixels_q[$];
  pixel_job_t    job_now;
  pixel_result_t result_want;
  int unsigned   error_count  = 0;
  int unsigned   cycle_count  = 0;
  int unsigned   send_gap     = 0;
  int unsigned   hold_left    = 0;
  bit            bursts_on    = 1'b1;
  bit            hold_request = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------------------
  // Escape-time model. All values are signed words with FRACTION_BITS fraction bits, kept
  // in 64-bit integers. Products are shifted right arithmetically, which rounds toward
  // minus infinity, and every stored value saturates to the 32-bit signed range.
  // ---------------------------------------------------------------------------------------

  function automatic longint clamp_word(input longint v);
    if (v > longint'(WORD_MAX)) return longint'(WORD_MAX);
    if (v < longint'(WORD_MIN)) return longint'(WORD_MIN);
    return v;
  endfunction

  // Scale a mapped coordinate by the zoom and add the offset; both steps saturate.
  function automatic longint scale_axis(input longint unit,
                                        input logic signed [WORD_W-1:0] offset);
    longint scaled;
    scaled = (unit * longint'(settings.zoom_factor)) >>> FRACTION_BITS;
    return clamp_word(clamp_word(scaled) + longint'(offset));
  endfunction

  function automatic pixel_result_t evaluate_pixel(input logic [COORD_W-1:0] col,
                                                   input logic [COORD_W-1:0] row);
    longint        fix_two, unit_re, unit_im, c_re, c_im, z_re, z_im, next_re, next_im;
    longint        lo, hi;
    logic [63:0]   magnitude, bound;
    int            limit, step;
    bit            gone;
    pixel_result_t res;
    fix_two = longint'(1) <<< (FRACTION_BITS + 1);
    // The pixel grid spans four units, from -2 to +2, on both axes; rows run downward.
    unit_re = clamp_word(((longint'(col) * 4) <<< FRACTION_BITS) / longint'(IMAGE_WIDTH)
                         - fix_two);
    unit_im = clamp_word(fix_two
                         - ((longint'(row) * 4) <<< FRACTION_BITS) / longint'(IMAGE_HEIGHT));
    c_re  = scale_axis(unit_re, settings.offset_real);
    c_im  = scale_axis(unit_im, settings.offset_imag);
    z_re  = 0;
    z_im  = 0;
    // |z|^2 carries twice the fraction bits, so the threshold is moved up to match.
    bound = 64'(settings.escape_limit) << FRACTION_BITS;
    limit = int'(settings.max_iterations);
    gone  = 1'b0;
    for (step = 0; step < limit; step++) begin
      next_re   = clamp_word(((z_re * z_re - z_im * z_im) >>> FRACTION_BITS) + c_re);
      next_im   = clamp_word(((z_re * z_im) >>> (FRACTION_BITS - 1)) + c_im);
      z_re      = next_re;
      z_im      = next_im;
      // Each square is below 2^63, but their sum may reach it: add them unsigned.
      magnitude = $unsigned(64'(z_re * z_re)) + $unsigned(64'(z_im * z_im));
      if (magnitude > bound) begin
        gone = 1'b1;
        break;
      end
    end
    res.col        = col;
    res.row        = row;
    res.escaped    = gone;
    res.iterations = ITER_W'(step);
    res.color      = settings.inside_color;
    if (gone) begin
      lo = longint'(settings.ramp_low_color);
      hi = longint'(settings.ramp_high_color);
      // A falling ramp rounds the whole color down too, so the step is rounded up.
      if (hi >= lo) begin
        res.color = COLOR_W'(lo + ((hi - lo) * step) / limit);
      end else begin
        res.color = COLOR_W'(lo - ((lo - hi) * step + limit - 1) / limit);
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Helpers for the stimulus process.
  // ---------------------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    if (error_count < PRINT_CAP) begin
      $display("%0t: mismatch: %s", $time, what);
    end
    error_count++;
  endtask

  // Writes one settings register. It returns on a falling edge, so queue work done right
  // after it never shares a time step with the driver.
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      REG_ZOOM:      settings.zoom_factor     = value[ZOOM_W-1:0];
      REG_OFF_REAL:  settings.offset_real     = value;
      REG_OFF_IMAG:  settings.offset_imag     = value;
      REG_MAX_ITER:  settings.max_iterations  = value[ITER_W-1:0];
      REG_ESC_LIMIT: settings.escape_limit    = value[LIMIT_W-1:0];
      REG_RAMP_LOW:  settings.ramp_low_color  = value[COLOR_W-1:0];
      REG_RAMP_HIGH: settings.ramp_high_color = value[COLOR_W-1:0];
      REG_INSIDE:    settings.inside_color    = value[COLOR_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic queue_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
    pixel_job_t job;
    job.col = col;
    job.row = row;
    pixel_jobs_q.push_back(job);
  endtask

  // Every pixel gives exactly one result word, so once the job queue is empty, the last
  // word has been taken and no pixel is pending, the unit is idle.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pixel_jobs_q.size() != 0 || pix_if.valid || pending_pixels_q.size() != 0);
  endtask

  // ---------------------------------------------------------------------------------------
  // Driver: offers queued pixel words, predicts each one as it is taken, and leaves a random
  // gap after some words while bursts are enabled.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_if.valid     <= 1'b0;
      pix_if.pixel_col <= '0;
      pix_if.pixel_row <= '0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        pending_pixels_q.push_back(evaluate_pixel(pix_if.pixel_col, pix_if.pixel_row));
      end
      if (!pix_if.valid || pix_if.ready) begin
        if (send_gap != 0) begin
          send_gap = send_gap - 1;
          pix_if.valid <= 1'b0;
        end else if (pixel_jobs_q.size() != 0) begin
          job_now = pixel_jobs_q.pop_front();
          pix_if.valid     <= 1'b1;
          pix_if.pixel_col <= job_now.col;
          pix_if.pixel_row <= job_now.row;
          if (bursts_on && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(1, 5);
          end
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor: checks each result word against the oldest pending pixel. Ready drops for
  // short random bursts, or for one long hold when the stimulus asks for it.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (pending_pixels_q.size() == 0) begin
          report_mismatch($sformatf("result word col=%0d row=%0d with no pixel pending",
                                    res_if.out_col, res_if.out_row));
        end else begin
          result_want = pending_pixels_q.pop_front();
          if (res_if.out_col !== result_want.col)
            report_mismatch($sformatf("out_col %0d, want %0d",
                                      res_if.out_col, result_want.col));
          if (res_if.out_row !== result_want.row)
            report_mismatch($sformatf("out_row %0d, want %0d",
                                      res_if.out_row, result_want.row));
          if (res_if.pixel_color !== result_want.color)
            report_mismatch($sformatf("pixel_color %06h, want %06h (col=%0d row=%0d)",
                                      res_if.pixel_color, result_want.color,
                                      result_want.col, result_want.row));
          if (res_if.escaped !== result_want.escaped)
            report_mismatch($sformatf("escaped %0b, want %0b (col=%0d row=%0d)",
                                      res_if.escaped, result_want.escaped,
                                      result_want.col, result_want.row));
          if (res_if.iteration_count !== result_want.iterations)
            report_mismatch($sformatf("iteration_count %0d, want %0d (col=%0d row=%0d)",
                                      res_if.iteration_count, result_want.iterations,
                                      result_want.col, result_want.row));
        end
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        res_if.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD - 1;
        res_if.ready <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 4);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog for a hung channel.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("mandelbrot_escape_time_pixel_unit verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus. Each phase sets the registers while the unit is idle, queues pixels and then
  // waits until every result has come back, so the sender pauses at every phase boundary.
  // ---------------------------------------------------------------------------------------
  initial begin
    logic [CFG_DATA_W-1:0] zoom_word;
    logic [CFG_DATA_W-1:0] real_word;
    logic [CFG_DATA_W-1:0] imag_word;
    logic [CFG_DATA_W-1:0] iter_word;
    logic [CFG_DATA_W-1:0] limit_word;

    pix_if.valid     = 1'b0;
    pix_if.pixel_col = '0;
    pix_if.pixel_row = '0;
    res_if.ready     = 1'b0;
    settings = '{zoom_factor:     31'h1000_0000,
                 offset_real:     32'sd0,
                 offset_imag:     32'sd0,
                 max_iterations:  12'd42,
                 escape_limit:    31'h4000_0000,
                 ramp_low_color:  24'h000000,
                 ramp_high_color: 24'hFFFFFF,
                 inside_color:    24'hFF6347};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Settings after reset: the four corners, the center, the real axis at -1 and +1, and (640, 300).
    queue_pixel(0, 0);
    queue_pixel(1023, 1023);
    queue_pixel(0, 1023);
    queue_pixel(1023, 0);
    queue_pixel(512, 512);
    queue_pixel(256, 512);
    queue_pixel(768, 512);
    queue_pixel(640, 300);
    wait_drained();

    // Pixel (768, 512) maps to c = 1, so its first |z|^2 is exactly 1.0. With the limit
    // at 1.0 it must not escape until the next iteration; just below it escapes at once.
    write_reg(REG_ESC_LIMIT, 32'h1000_0000);
    queue_pixel(768, 512);
    wait_drained();
    write_reg(REG_ESC_LIMIT, 32'h0FFF_FFFF);
    queue_pixel(768, 512);
    wait_drained();

    // An iteration limit of zero runs no iteration at all: every pixel is inside.
    write_reg(REG_ESC_LIMIT, 32'h4000_0000);
    write_reg(REG_MAX_ITER, 32'd0);
    queue_pixel(768, 512);
    queue_pixel(0, 0);
    wait_drained();

    // A falling color ramp, from white at iteration zero down toward black.
    write_reg(REG_MAX_ITER, 32'd7);
    write_reg(REG_RAMP_LOW, 32'h00FF_FFFF);
    write_reg(REG_RAMP_HIGH, 32'h0000_0000);
    queue_pixel(0, 0);
    queue_pixel(1023, 0);
    queue_pixel(700, 700);
    queue_pixel(768, 512);
    wait_drained();

    // A zero threshold: only the origin itself stays inside.
    write_reg(REG_ESC_LIMIT, 32'h0000_0000);
    queue_pixel(512, 512);
    queue_pixel(513, 512);
    wait_drained();

    // Largest zoom with offsets at both ends: the mapping saturates on both axes, and the
    // corner at (0, 0) lands next to the origin and runs the full 4095 iterations.
    write_reg(REG_ZOOM, 32'h7FFF_FFFF);
    write_reg(REG_OFF_REAL, 32'h7FFF_FFFF);
    write_reg(REG_OFF_IMAG, 32'h8000_0000);
    write_reg(REG_MAX_ITER, 32'd4095);
    write_reg(REG_ESC_LIMIT, 32'h7FFF_FFFF);
    write_reg(REG_INSIDE, 32'h0000_0000);
    queue_pixel(0, 0);
    queue_pixel(1023, 1023);
    queue_pixel(512, 512);
    wait_drained();

    // Zero zoom collapses every pixel onto the origin.
    write_reg(REG_ZOOM, 32'h0000_0000);
    write_reg(REG_OFF_REAL, 32'h0000_0000);
    write_reg(REG_OFF_IMAG, 32'h0000_0000);
    queue_pixel(5, 5);
    queue_pixel(1000, 3);
    wait_drained();

    // Random phases. Most of them look at the interesting part of the plane with short
    // iteration limits; one uses longer limits and one very short ones.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0:       zoom_word = 32'h1000_0000;
        1:       zoom_word = $urandom_range(32'h0040_0000, 32'h2000_0000);
        2:       zoom_word = $urandom() & 32'h7FFF_FFFF;
        default: zoom_word = $urandom_range(32'h0100_0000, 32'h0800_0000);
      endcase
      real_word = ($urandom_range(0, 3) == 0) ? $urandom()
                  : $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
      imag_word = ($urandom_range(0, 3) == 0) ? $urandom()
                  : $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
      if (p == 3)      iter_word = $urandom_range(100, 400);
      else if (p == 7) iter_word = $urandom_range(1, 4);
      else             iter_word = $urandom_range(8, 64);
      limit_word = ($urandom_range(0, 3) == 0) ? ($urandom() & 32'h7FFF_FFFF)
                   : 32'h4000_0000;
      write_reg(REG_ZOOM, zoom_word);
      write_reg(REG_OFF_REAL, real_word);
      write_reg(REG_OFF_IMAG, imag_word);
      write_reg(REG_MAX_ITER, iter_word);
      write_reg(REG_ESC_LIMIT, limit_word);
      write_reg(REG_RAMP_LOW, $urandom() & 32'h00FF_FFFF);
      write_reg(REG_RAMP_HIGH, $urandom() & 32'h00FF_FFFF);
      write_reg(REG_INSIDE, $urandom() & 32'h00FF_FFFF);
      // The last two phases run with both channels flat out.
      if (p >= RANDOM_PHASES - 2) bursts_on = 1'b0;
      for (int k = 0; k < PHASE_PIXELS; k++) begin
        queue_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
      end
      // Hold the output back long enough that the unit stops taking new pixels.
      if (p == 2) hold_request = 1'b1;
      wait_drained();
    end

    // Let any stray result word show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_pixels_q.size() != 0) begin
      report_mismatch($sformatf("%0d result words never arrived", pending_pixels_q.size()));
    end
    if (error_count == 0) begin
      $display("mandelbrot_escape_time_pixel_unit verification clean");
    end else begin
      $display("mandelbrot_escape_time_pixel_unit verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/mbe_pkg.sv
rtl/core/mbe_in_if.sv
rtl/core/mbe_out_if.sv
rtl/core/mbe_div.sv
rtl/core/mbe_dp.sv
rtl/core/mbe_ctrl.sv
rtl/core/mandelbrot_escape_time_pixel_unit.sv
verif/mandelbrot_escape_time_pixel_unit_test.sv
